FILE: rtl/gbmd_pkg.sv
// shared constants and types for the greedy block match delta core
package gbmd_pkg;
    localparam int BufDepth   = 1024;
    localparam int AddrW      = $clog2(BufDepth);
    localparam int LenW       = AddrW + 1;
    localparam int MaxRecords = 60;
    localparam int CntW       = $clog2(MaxRecords + 1);
    localparam logic [LenW-1:0] MinMatchReset = LenW'(16);

    localparam logic [1:0] FUNC_WR_TGT = 2'd0;
    localparam logic [1:0] FUNC_WR_REF = 2'd1;
    localparam logic [1:0] FUNC_RUN    = 2'd2;

    typedef struct packed {
        logic            found;
        logic [AddrW-1:0] ref_pos;
        logic [AddrW-1:0] target_pos;
        logic [LenW-1:0]  match_len;
        logic            last;
    } rec_t;
endpackage

FILE: rtl/gbmd_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
module gbmd_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/greedy_block_match_delta_core.sv
// top level of the greedy block match delta core
// load items (func 0, 1) write straight to the rams, busy stays low
// a run item visits each searched position; per reference offset it issues a read
// and compares byte pairs until a mismatch or the bound stops it, then decides on a
// record per position and ends by emitting the final record
// records appear one per strobe cycle, the receiver cannot stall
// asynchronous active-low reset returns control to idle and min_match to 16
module greedy_block_match_delta_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic [gbmd_pkg::AddrW-1:0]   addr,
    input  logic [7:0]                   data_byte,
    input  logic [gbmd_pkg::LenW-1:0]    target_len,
    input  logic [gbmd_pkg::LenW-1:0]    ref_len,
    input  logic                         cfg_we,
    input  logic [gbmd_pkg::LenW-1:0]    cfg_data,
    output logic                         strobe,
    output logic                         found,
    output logic [gbmd_pkg::AddrW-1:0]   ref_pos,
    output logic [gbmd_pkg::AddrW-1:0]   target_pos,
    output logic [gbmd_pkg::LenW-1:0]    match_len,
    output logic                         last
);
    localparam int AW = gbmd_pkg::AddrW;
    localparam int LW = gbmd_pkg::LenW;
    localparam logic [LW-1:0] Depth = LW'(gbmd_pkg::BufDepth);

    // state codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POS  = 3'd1; // start a new target position
    localparam logic [2:0] ST_OFF  = 3'd2; // issue first read at an offset
    localparam logic [2:0] ST_CMP  = 3'd3; // compare returned bytes
    localparam logic [2:0] ST_DEC  = 3'd4; // decide after all offsets
    localparam logic [2:0] ST_END  = 3'd5; // emit final record

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] min_match_reg;
    logic [LW-1:0] tlen_reg, rlen_reg;
    logic [LW-1:0] s_reg, i_reg, j_reg;
    logic [LW-1:0] best_len_reg, best_pos_reg;
    logic [gbmd_pkg::CntW-1:0] count_reg;
    logic          pend_reg;  // a match record held back until the next is known
    gbmd_pkg::rec_t pend_rec_reg, out_rec_reg;
    logic          strobe_reg;
    logic          rd_valid_reg; // rdata corresponds to the last issued read

    logic          accept;
    logic [LW-1:0] tl_sat, rl_sat;
    logic          t_we, r_we;
    logic [AW-1:0] t_raddr, r_raddr;
    logic [7:0]    t_rdata, r_rdata;
    logic [LW-1:0] remain, lim, j_plus;
    logic [LW-1:0] rd_t, rd_r;
    logic          issue;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign tl_sat = (target_len > Depth) ? Depth : target_len;
    assign rl_sat = (ref_len > Depth) ? Depth : ref_len;

    // loads go straight to the rams, only while idle
    assign t_we = accept && (func == gbmd_pkg::FUNC_WR_TGT);
    assign r_we = accept && (func == gbmd_pkg::FUNC_WR_REF);

    assign remain = tlen_reg - s_reg;
    assign lim    = ((rlen_reg - i_reg) < remain) ? (rlen_reg - i_reg) : remain;
    assign j_plus = j_reg + LW'(1);

    // read address: next byte pair to compare
    always_comb
    begin
        rd_t  = s_reg + j_reg;
        rd_r  = i_reg + j_reg;
        issue = 1'b0;
        if (state_reg == ST_OFF)
        begin
            issue = (lim != '0);
        end
        else if (state_reg == ST_CMP && rd_valid_reg && t_rdata == r_rdata
                 && j_plus < lim)
        begin
            rd_t  = s_reg + j_plus;
            rd_r  = i_reg + j_plus;
            issue = 1'b1;
        end
    end
    assign t_raddr = rd_t[AW-1:0];
    assign r_raddr = rd_r[AW-1:0];

    gbmd_ram #(.Width(8), .Depth(gbmd_pkg::BufDepth)) u_tgt_ram (
        .clk(clk), .we(t_we), .waddr(addr), .wdata(data_byte),
        .raddr(t_raddr), .rdata(t_rdata)
    );
    gbmd_ram #(.Width(8), .Depth(gbmd_pkg::BufDepth)) u_ref_ram (
        .clk(clk), .we(r_we), .waddr(addr), .wdata(data_byte),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    // run sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_match_reg <= gbmd_pkg::MinMatchReset;
            strobe_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            count_reg     <= '0;
            tlen_reg      <= '0;
            rlen_reg      <= '0;
            s_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            best_len_reg  <= '0;
            best_pos_reg  <= '0;
            pend_rec_reg  <= '0;
            out_rec_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            strobe_reg   <= 1'b0;
            rd_valid_reg <= issue;
            if (cfg_we)
            begin
                min_match_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && func == gbmd_pkg::FUNC_RUN)
                    begin
                        tlen_reg  <= tl_sat;
                        rlen_reg  <= rl_sat;
                        s_reg     <= '0;
                        count_reg <= '0;
                        pend_reg  <= 1'b0;
                    end
                end
                ST_POS:
                begin
                    i_reg        <= '0;
                    j_reg        <= '0;
                    best_len_reg <= '0;
                    best_pos_reg <= '0;
                end
                ST_OFF:
                begin
                    j_reg <= '0;
                end
                ST_CMP:
                begin
                    if (rd_valid_reg && t_rdata == r_rdata && j_plus < lim)
                    begin
                        j_reg <= j_plus;
                    end
                    else
                    begin
                        // run length at this offset ends here
                        if ((rd_valid_reg && t_rdata == r_rdata ? j_plus : j_reg)
                            > best_len_reg)
                        begin
                            best_len_reg <= (rd_valid_reg && t_rdata == r_rdata)
                                            ? j_plus : j_reg;
                            best_pos_reg <= i_reg;
                        end
                        i_reg <= i_reg + LW'(1);
                        j_reg <= '0;
                    end
                end
                ST_DEC:
                begin
                    if (best_len_reg > min_match_reg)
                    begin
                        if (pend_reg)
                        begin
                            out_rec_reg <= pend_rec_reg;
                            strobe_reg  <= 1'b1;
                        end
                        pend_reg                <= 1'b1;
                        pend_rec_reg.found      <= 1'b1;
                        pend_rec_reg.ref_pos    <= best_pos_reg[AW-1:0];
                        pend_rec_reg.target_pos <= s_reg[AW-1:0];
                        pend_rec_reg.match_len  <= best_len_reg;
                        pend_rec_reg.last       <= 1'b0;
                        count_reg <= count_reg + gbmd_pkg::CntW'(1);
                        s_reg     <= s_reg + best_len_reg;
                    end
                    else
                    begin
                        s_reg <= s_reg + LW'(1);
                    end
                end
                ST_END:
                begin
                    strobe_reg <= 1'b1;
                    if (pend_reg)
                    begin
                        out_rec_reg <= '{found: pend_rec_reg.found,
                                         ref_pos: pend_rec_reg.ref_pos,
                                         target_pos: pend_rec_reg.target_pos,
                                         match_len: pend_rec_reg.match_len,
                                         last: 1'b1};
                    end
                    else
                    begin
                        out_rec_reg <= '{found: 1'b0, ref_pos: '0, target_pos: '0,
                                         match_len: '0, last: 1'b1};
                    end
                    pend_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == gbmd_pkg::FUNC_RUN)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                if (s_reg + LW'(1) < tlen_reg && count_reg < gbmd_pkg::CntW'(
                    gbmd_pkg::MaxRecords))
                begin
                    state_next = (rlen_reg == '0) ? ST_DEC : ST_OFF;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_OFF:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!(rd_valid_reg && t_rdata == r_rdata && j_plus < lim))
                begin
                    // full-remaining match cannot be beaten by a later offset
                    if ((rd_valid_reg && t_rdata == r_rdata && j_plus == remain
                         && j_plus > best_len_reg)
                        || i_reg + LW'(1) >= rlen_reg)
                    begin
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        state_next = ST_OFF;
                    end
                end
            end
            ST_DEC:
            begin
                state_next = ST_POS;
            end
            ST_END:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign strobe     = strobe_reg;
    assign found      = out_rec_reg.found;
    assign ref_pos    = out_rec_reg.ref_pos;
    assign target_pos = out_rec_reg.target_pos;
    assign match_len  = out_rec_reg.match_len;
    assign last       = out_rec_reg.last;

    // run count never exceeds the record limit
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gbmd_pkg::CntW'(gbmd_pkg::MaxRecords))
        else $error("record count overflow");
    // final record is followed by idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_END |=> state_reg == ST_IDLE && strobe && last)
        else $error("final record not emitted");
    // no record other than the final one outside a run
    a_no_idle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("record outside a run");
endmodule
